### rtl/core/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
`default_nettype none
package bfa_pkg;

  localparam int unsigned FRAME_COUNT_DEF = 32768;
  localparam int unsigned WORD_BITS_DEF   = 32;
  localparam int unsigned FRAME_NUM_W     = 20;
  localparam int unsigned FRAME_SHIFT     = 12;
  localparam int unsigned TOTAL_W         = 16;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_REGION_SET = 2'd2,
    OP_REGION_CLR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FRAME     = 2'd1,
    ST_DOUBLE_FREE  = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_SET,
    K_CLR,
    K_OOR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [FRAME_NUM_W-1:0] lo;
    logic [FRAME_NUM_W:0]   hi;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } back_state_t;

endpackage
`default_nettype wire

### rtl/core/bitmap_frame_allocator.sv
// Top level of the first-fit bitmap frame allocator.
//
// Command channel: op, address and size are taken at a clock edge with start
// high and busy low. A two-entry command queue sits between the front end and
// the bitmap engine, so up to two commands may wait while one is in work.
// Result channel: done pulses for one cycle with frame_address and status.
// The receiver cannot hold results off; results leave in command order.
// Allocate walks words from word 0 up to the first free frame (at most
// min(total_frames, FRAME_COUNT) / WORD_BITS words, rounded up); free
// takes one word, out of range none; region commands take each word the
// region touches within capacity. The engine visits one bitmap word per cycle.
// Reset: rst clears the control state and total_frames, then a clearing pass
// over FRAME_COUNT / WORD_BITS words (1024 by default) zeroes the bitmap, so
// every frame starts reserved; busy stays high during it. cfg_we writes
// total_frames at any edge; write it only while no command is in work.
`default_nettype none
module bitmap_frame_allocator #(
  parameter int unsigned FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned WORD_BITS   = bfa_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  op,
  input  wire logic [31:0]                 address,
  input  wire logic [31:0]                 size,
  input  wire logic                        cfg_we,
  input  wire logic [bfa_pkg::TOTAL_W-1:0] cfg_wdata,
  output logic                             done,
  output logic [31:0]                      frame_address,
  output logic [1:0]                       status
);

  bfa_pkg::back_status_t back_st;
  bfa_pkg::cmd_t         head;
  logic                  head_valid;

  bfa_front #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .address   (address),
    .size      (size),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .back_st   (back_st),
    .head_valid(head_valid),
    .head      (head)
  );

  bfa_back #(
    .FRAME_COUNT(FRAME_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .back_st      (back_st),
    .done         (done),
    .frame_address(frame_address),
    .status       (status)
  );

endmodule
`default_nettype wire

### rtl/core/bfa_front.sv
// Front end: accepts commands, classifies them into frame ranges and queues them.
`default_nettype none
module bfa_front #(
  parameter int unsigned FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op,
  input  wire logic [31:0]                   address,
  input  wire logic [31:0]                   size,
  input  wire logic                          cfg_we,
  input  wire logic [bfa_pkg::TOTAL_W-1:0]   cfg_wdata,
  input  wire bfa_pkg::back_status_t         back_st,
  output logic                               head_valid,
  output bfa_pkg::cmd_t                      head
);

  localparam int unsigned FW = bfa_pkg::FRAME_NUM_W;
  localparam logic [FW:0] FC = (FW+1)'(FRAME_COUNT);

  logic [bfa_pkg::TOTAL_W-1:0] total_frames;
  bfa_pkg::cmd_t               q [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic [1:0]                  count_next;

  logic [FW-1:0] frame;
  logic [FW:0]   frame_ext;
  logic [FW:0]   region_end;
  logic [FW:0]   limit;
  logic [FW:0]   tf_ext;
  bfa_pkg::cmd_t cmd;
  logic          push;

  assign frame      = address[31 -: FW];
  assign frame_ext  = {1'b0, frame};
  assign region_end = frame_ext + {1'b0, size[31 -: FW]};
  assign tf_ext     = (FW+1)'(total_frames);
  assign limit      = (tf_ext > FC) ? FC : tf_ext;

  always_comb begin
    cmd.lo = frame;
    cmd.hi = (region_end > FC) ? FC : region_end;
    unique case (bfa_pkg::op_t'(op))
      bfa_pkg::OP_ALLOC: begin
        cmd.kind = bfa_pkg::K_ALLOC;
        cmd.lo   = FW'(1);
        cmd.hi   = limit;
      end
      bfa_pkg::OP_FREE: begin
        cmd.kind = (frame_ext >= FC) ? bfa_pkg::K_OOR : bfa_pkg::K_FREE;
        cmd.hi   = frame_ext + (FW+1)'(1);
      end
      bfa_pkg::OP_REGION_SET: cmd.kind = bfa_pkg::K_SET;
      bfa_pkg::OP_REGION_CLR: cmd.kind = bfa_pkg::K_CLR;
      default:                cmd.kind = bfa_pkg::K_SET;
    endcase
  end

  assign busy       = (count == 2'd2) || back_st.clearing;
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !back_st.pop) begin
      count_next = count + 2'd1;
    end else if (!push && back_st.pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= '0;
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        total_frames <= cfg_wdata;
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (back_st.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bfa_back.sv
// Back end: clears the bitmap after reset and walks bitmap words to carry out commands.
`default_nettype none
module bfa_back #(
  parameter int unsigned FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned WORD_BITS   = bfa_pkg::WORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire bfa_pkg::cmd_t    head,
  output bfa_pkg::back_status_t back_st,
  output logic                  done,
  output logic [31:0]           frame_address,
  output logic [1:0]            status
);

  localparam int unsigned FW        = bfa_pkg::FRAME_NUM_W;
  localparam int unsigned WSH       = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIW       = $clog2(MAP_WORDS);
  localparam logic [WIW-1:0] LAST_WORD = WIW'(MAP_WORDS - 1);
  localparam logic [FW:0] WSTEP = (FW+1)'(WORD_BITS);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [WIW-1:0]       waddr;
  logic [WIW-1:0]       raddr;
  logic [WORD_BITS-1:0] wdata;

  bfa_pkg::back_state_t state;
  bfa_pkg::back_state_t state_next;
  bfa_pkg::cmd_t        cmd;
  bfa_pkg::cmd_t        cmd_next;
  logic [FW:0]          wbase;
  logic [FW:0]          wbase_next;
  logic [WIW-1:0]       clr_idx;
  logic                 done_next;
  logic [31:0]          addr_next;
  bfa_pkg::status_t     status_next;

  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] sel;
  logic [WSH-1:0]       pick;
  logic [FW:0]          head_base;
  logic [FW:0]          step_base;
  logic [FW:0]          found;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      range_mask[j] = ((wbase + (FW+1)'(j)) >= {1'b0, cmd.lo}) &&
                      ((wbase + (FW+1)'(j)) < cmd.hi);
    end
    sel  = rdata & range_mask;
    pick = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (sel[j]) begin
        pick = WSH'(j);
      end
    end
  end

  assign head_base = {1'b0, head.lo} & ~(FW+1)'(WORD_BITS - 1);
  assign step_base = wbase + WSTEP;
  assign found     = wbase + (FW+1)'(pick);

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    wbase_next   = wbase;
    back_st      = '0;
    mem_we       = 1'b0;
    waddr        = wbase[WSH +: WIW];
    wdata        = rdata;
    raddr        = wbase[WSH +: WIW];
    done_next    = 1'b0;
    addr_next    = '0;
    status_next  = bfa_pkg::ST_OK;
    unique case (state)
      bfa_pkg::S_CLEAR: begin
        back_st.clearing = 1'b1;
        mem_we           = 1'b1;
        waddr            = clr_idx;
        wdata            = '0;
        if (clr_idx == LAST_WORD) begin
          state_next = bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_IDLE: begin
        if (head_valid) begin
          back_st.pop = 1'b1;
          cmd_next    = head;
          wbase_next  = head_base;
          raddr       = head_base[WSH +: WIW];
          if (head.kind == bfa_pkg::K_OOR) begin
            done_next   = 1'b1;
            status_next = bfa_pkg::ST_OUT_OF_RANGE;
          end else if (head_base >= head.hi) begin
            done_next   = 1'b1;
            status_next = (head.kind == bfa_pkg::K_ALLOC) ? bfa_pkg::ST_NO_FRAME
                                                           : bfa_pkg::ST_OK;
          end else begin
            state_next = bfa_pkg::S_EVAL;
          end
        end
      end
      bfa_pkg::S_EVAL: begin
        wbase_next = step_base;
        raddr      = step_base[WSH +: WIW];
        unique case (cmd.kind)
          bfa_pkg::K_ALLOC: begin
            if (|sel) begin
              mem_we      = 1'b1;
              wdata       = rdata & ~(WORD_BITS'(1) << pick);
              done_next   = 1'b1;
              addr_next   = {found[FW-1:0], bfa_pkg::FRAME_SHIFT'(0)};
              state_next  = bfa_pkg::S_IDLE;
            end else if (step_base >= cmd.hi) begin
              done_next   = 1'b1;
              status_next = bfa_pkg::ST_NO_FRAME;
              state_next  = bfa_pkg::S_IDLE;
            end
          end
          bfa_pkg::K_FREE: begin
            done_next  = 1'b1;
            state_next = bfa_pkg::S_IDLE;
            if (|sel) begin
              status_next = bfa_pkg::ST_DOUBLE_FREE;
            end else begin
              mem_we = 1'b1;
              wdata  = rdata | range_mask;
            end
          end
          bfa_pkg::K_SET, bfa_pkg::K_CLR: begin
            mem_we = 1'b1;
            wdata  = (cmd.kind == bfa_pkg::K_SET) ? (rdata | range_mask)
                                                  : (rdata & ~range_mask);
            if (step_base >= cmd.hi) begin
              done_next  = 1'b1;
              state_next = bfa_pkg::S_IDLE;
            end
          end
          default: begin
            done_next   = 1'b1;
            status_next = bfa_pkg::ST_OUT_OF_RANGE;
            state_next  = bfa_pkg::S_IDLE;
          end
        endcase
      end
      default: state_next = bfa_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bfa_pkg::S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == bfa_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + WIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd           <= cmd_next;
    wbase         <= wbase_next;
    frame_address <= addr_next;
    status        <= status_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/bfa_checker.sv
// Port-level checker for the bitmap frame allocator, bound to the top level.
`default_nettype none
module bfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] frame_address,
  input wire logic [1:0]  status
);

  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && status != bfa_pkg::ST_OK) |-> frame_address == 32'd0)
    else $error("address given with failing status");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> frame_address[11:0] == 12'd0)
    else $error("frame address not frame aligned");

  a_release_clearing: assert property (@(posedge clk)
    $fell(rst) |-> (busy && !done))
    else $error("not clearing when reset is released");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .frame_address(frame_address),
  .status       (status)
);
`default_nettype wire

### tb/sv/bitmap_frame_allocator_tb.sv
// Self-checking testbench for the bitmap frame allocator.
`timescale 1ns / 1ps
module bitmap_frame_allocator_tb;

  localparam int unsigned FRAMES = 32768;
  localparam int unsigned BURSTS_ITEMS = 900;

  typedef struct {
    logic [31:0]      frame_address;
    bfa_pkg::status_t status;
  } alloc_result_t;

  class frame_map_scoreboard;
    bit            frame_free[FRAMES];
    int unsigned   total_frames;
    alloc_result_t pending_results[$];
    int            mismatches;

    function void mark_frames(logic [31:0] addr, logic [31:0] len, bit v);
      int unsigned base;
      int unsigned stop;
      base = addr >> 12;
      stop = base + (len >> 12);
      if (stop > FRAMES) stop = FRAMES;
      for (int unsigned f = base; f < stop; f++) frame_free[f] = v;
    endfunction

    function void note_command(bfa_pkg::op_t op, logic [31:0] addr, logic [31:0] len);
      alloc_result_t r;
      int unsigned lim;
      int unsigned f;
      r.frame_address = '0;
      r.status = bfa_pkg::ST_OK;
      case (op)
        bfa_pkg::OP_ALLOC: begin
          lim = (total_frames > FRAMES) ? FRAMES : total_frames;
          r.status = bfa_pkg::ST_NO_FRAME;
          for (f = 1; f < lim; f++) begin
            if (frame_free[f]) begin
              frame_free[f] = 0;
              r.frame_address = f << 12;
              r.status = bfa_pkg::ST_OK;
              break;
            end
          end
        end
        bfa_pkg::OP_FREE: begin
          f = addr >> 12;
          if (f >= FRAMES) r.status = bfa_pkg::ST_OUT_OF_RANGE;
          else if (frame_free[f]) r.status = bfa_pkg::ST_DOUBLE_FREE;
          else frame_free[f] = 1;
        end
        bfa_pkg::OP_REGION_SET: mark_frames(addr, len, 1);
        default: mark_frames(addr, len, 0);
      endcase
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [31:0] fa, logic [1:0] st);
      alloc_result_t r;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction addr=%h status=%0d", fa, st));
      end else begin
        r = pending_results.pop_front();
        if (fa !== r.frame_address)
          report_mismatch($sformatf("frame_address %h, want %h", fa, r.frame_address));
        if (st !== r.status)
          report_mismatch($sformatf("status %0d, want %0d", st, r.status));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [31:0] address;
  logic [31:0] size;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        done;
  logic [31:0] frame_address;
  logic [1:0]  status;

  frame_map_scoreboard sb;

  bitmap_frame_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .address(address),
    .size(size), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
    .frame_address(frame_address), .status(status)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(frame_address, status);
  end

  task send_command(bfa_pkg::op_t o, logic [31:0] a, logic [31:0] s);
    start <= 1'b1;
    op <= o;
    address <= a;
    size <= s;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(o, a, s);
    @(negedge clk);
  endtask

  task idle_cycles(int n);
    start <= 1'b0;
    op <= 2'($urandom);
    repeat (n) @(negedge clk);
  endtask

  task drain;
    idle_cycles(1);
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_total(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.total_frames = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 16'($urandom);
    @(negedge clk);
  endtask

  task send_random(int unsigned lim);
    int unsigned r;
    int unsigned f;
    r = $urandom_range(0, 99);
    f = $urandom_range(0, lim);
    if (r < 35) begin
      send_command(bfa_pkg::OP_ALLOC, $urandom, $urandom);
    end else if (r < 60) begin
      send_command(bfa_pkg::OP_FREE, (f << 12) | $urandom_range(0, 4095), $urandom);
    end else if (r < 80) begin
      send_command(bfa_pkg::OP_REGION_SET, (f << 12) | $urandom_range(0, 4095),
                   ($urandom_range(0, 40) << 12) | $urandom_range(0, 4095));
    end else if (r < 90) begin
      send_command(bfa_pkg::OP_REGION_CLR, (f << 12) | $urandom_range(0, 4095),
                   ($urandom_range(0, 20) << 12) | $urandom_range(0, 4095));
    end else begin
      send_command(bfa_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned lim;
    int unsigned sent;
    int unsigned burst;
    logic [15:0] totals[6];
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    op = bfa_pkg::OP_ALLOC;
    address = '0;
    size = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_FREE, 32'h0000_0fff, 32'hffff_ffff);
    send_command(bfa_pkg::OP_FREE, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_FREE, 32'hffff_ffff, 32'h0);
    send_command(bfa_pkg::OP_FREE, 32'd32767 << 12, 32'h0);
    send_command(bfa_pkg::OP_REGION_SET, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_REGION_SET, 32'h1000, 32'd10 * 4096 + 4095);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    write_total(16'd1);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    write_total(16'hffff);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_REGION_CLR, 32'hffff_f000, 32'hffff_ffff);
    send_command(bfa_pkg::OP_REGION_SET, 32'd32760 << 12, 32'hffff_ffff);
    send_command(bfa_pkg::OP_REGION_CLR, 32'h0, 32'd12 << 12);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_FREE, 32'd32767 << 12, 32'h0);
    send_command(bfa_pkg::OP_REGION_CLR, 32'h0, 32'hffff_ffff);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    write_total(16'd32768);
    send_command(bfa_pkg::OP_REGION_SET, 32'd32767 << 12, 32'h1000);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);
    send_command(bfa_pkg::OP_ALLOC, 32'h0, 32'h0);

    totals[0] = 16'd300;
    totals[1] = 16'd32768;
    totals[2] = 16'hffff;
    totals[3] = 16'd2;
    totals[4] = 16'($urandom_range(3, 600));
    totals[5] = 16'd0;
    for (int ph = 0; ph < 6; ph++) begin
      write_total(totals[ph]);
      lim = (totals[ph] < 64) ? 64 : ((totals[ph] > 400) ? 400 : totals[ph]);
      sent = 0;
      while (sent < BURSTS_ITEMS / 6) begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          send_random(lim);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 15));
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
